// File: design/button_debounce_press_classifier_assert.svh
// ----------------------------------------------------------------------------
// Button debounce assertion macros
// Concurrent assertion wrappers shared by the RTL of the press classifier.
// Defining NO_ASSERTIONS removes every check.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property holds at every rising clock edge outside reset.
`define BDPC_ASSERT(name, prop, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: name");

// An implication from one cycle to the next.
`define BDPC_ASSERT_NEXT(name, ante, cons, clk, rst_n) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: name");

`else

`define BDPC_ASSERT(name, prop, clk, rst_n)
`define BDPC_ASSERT_NEXT(name, ante, cons, clk, rst_n)

`endif

`endif

// File: design/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// Button debounce package
// Types and constants shared by the press classifier and its button slices.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned TICK_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] DEBOUNCE_RST    = 16'd50;
  localparam logic [CFG_W-1:0] SHORT_LIMIT_RST = 16'd500;
  localparam logic [CFG_W-1:0] LONG_LIMIT_RST  = 16'd2000;

  // Per-button event code.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_SHORT   = 2'd1,
    EV_LONG    = 2'd2,
    EV_HOLDING = 2'd3
  } press_ev_e;

  // Configuration register index.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE    = 2'd0,
    CFG_SHORT_LIMIT = 2'd1,
    CFG_LONG_LIMIT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] short_limit_ms;
    logic [CFG_W-1:0] long_limit_ms;
  } cfg_t;

  // Per-poll status of one button.
  typedef struct packed {
    logic      changed;
    press_ev_e ev;
  } btn_res_t;

endpackage

// File: design/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// Button debounce press classifier
// Debounces active-low button levels polled with a millisecond tick and
// reports short, long and holding presses per button.
// ----------------------------------------------------------------------------
//  channel  | signals                                     | direction
//  ---------+---------------------------------------------+----------
//  in       | in_valid_i/in_ready_o, now_ms_i, raw_levels_i | sink
//  out      | out_valid_o/out_ready_i, pressed_mask_o,    | source
//           | press_events_o, last_change_ms_o            |
//  cfg      | cfg_valid_i/cfg_ready_o, cfg_index_i,       | sink
//           | cfg_data_i                                  |
//
// The work stage sustains one transaction per cycle while the result side
// accepts; a poll passes through the input register, then the result register.
// The input register and the result register decouple the two sides, so a
// new poll can enter an empty input register while an unread result waits.
// Reset clears all button state and loads the default limits (50/500/2000).
// Configuration writes are always accepted.
// ----------------------------------------------------------------------------
`include "button_debounce_press_classifier_assert.svh"

module button_debounce_press_classifier #(
  parameter int unsigned NUM_BUTTONS = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bdpc_pkg::TICK_W-1:0]    now_ms_i,
  input  logic [NUM_BUTTONS-1:0]         raw_levels_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [NUM_BUTTONS-1:0]         pressed_mask_o,
  output logic [2*NUM_BUTTONS-1:0]       press_events_o,
  output logic [bdpc_pkg::TICK_W-1:0]    last_change_ms_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bdpc_pkg::CFG_W-1:0]     cfg_data_i
);
  import bdpc_pkg::*;

  cfg_t                   cfg_q;
  logic                   in_valid_q;
  logic [TICK_W-1:0]      now_q;
  logic [NUM_BUTTONS-1:0] raw_q;
  logic                   out_valid_q;
  logic [2*NUM_BUTTONS-1:0] events_q, events_d;
  logic [TICK_W-1:0]      any_change_q;
  logic [NUM_BUTTONS-1:0] btn_changed;
  logic                   advance;
  btn_res_t               btn_res [NUM_BUTTONS];

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms    <= DEBOUNCE_RST;
      cfg_q.short_limit_ms <= SHORT_LIMIT_RST;
      cfg_q.long_limit_ms  <= LONG_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE:    cfg_q.debounce_ms    <= cfg_data_i;
        CFG_SHORT_LIMIT: cfg_q.short_limit_ms <= cfg_data_i;
        CFG_LONG_LIMIT:  cfg_q.long_limit_ms  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Work stage moves when it holds a poll and the result slot is free or being read.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q <= now_ms_i;
      raw_q <= raw_levels_i;
    end
  end

  // One slice per button; pins are active low.
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_btn
    bdpc_button u_button (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (advance),
      .now_i     (now_q),
      .sense_i   (~raw_q[g]),
      .cfg_i     (cfg_q),
      .pressed_o (pressed_mask_o[g]),
      .res_o     (btn_res[g])
    );
    assign events_d[2*g +: 2] = btn_res[g].ev;
    assign btn_changed[g]     = btn_res[g].changed;
  end

  // Result register and the shared change tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      any_change_q <= '0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance && (|btn_changed)) begin
        any_change_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      events_q <= events_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign press_events_o   = events_q;
  assign last_change_ms_o = any_change_q;

  // Checks.
  `BDPC_ASSERT_NEXT(a_advance_gives_result, advance, out_valid_q, clk_i, rst_ni)
  `BDPC_ASSERT_NEXT(a_stalled_poll_kept, in_valid_q && !advance, in_valid_q, clk_i, rst_ni)
  `BDPC_ASSERT(a_holding_is_pressed,
      !out_valid_o || (press_events_o[1:0] != EV_HOLDING) || pressed_mask_o[0], clk_i, rst_ni)
  `BDPC_ASSERT(a_release_not_pressed,
      !out_valid_o || ((press_events_o[1:0] != EV_SHORT) && (press_events_o[1:0] != EV_LONG))
      || !pressed_mask_o[0], clk_i, rst_ni)

endmodule

// File: design/bdpc_button.sv
// ----------------------------------------------------------------------------
// Button slice
// Debounce state and press classification of a single button.
// ----------------------------------------------------------------------------
module bdpc_button (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [bdpc_pkg::TICK_W-1:0] now_i,
  input  logic                        sense_i,
  input  bdpc_pkg::cfg_t              cfg_i,
  output logic                        pressed_o,
  output bdpc_pkg::btn_res_t          res_o
);
  import bdpc_pkg::*;

  logic              last_raw_q, last_raw_d;
  logic              deb_q, deb_d;
  logic [TICK_W-1:0] stable_q, stable_d;
  logic [TICK_W-1:0] changed_q, changed_d;
  logic [TICK_W-1:0] since_ms;
  logic [TICK_W-1:0] held_ms;
  logic [TICK_W-1:0] hold_age;
  logic              raw_moved;
  logic              accept;

  // Raw level tracking: a change restarts the stable timer.
  always_comb begin
    raw_moved  = (sense_i != last_raw_q);
    last_raw_d = sense_i;
    stable_d   = raw_moved ? now_i : stable_q;
    since_ms   = raw_moved ? '0 : (now_i - stable_q);
    accept     = (sense_i != deb_q) && (since_ms >= {{(TICK_W-CFG_W){1'b0}}, cfg_i.debounce_ms});
    held_ms    = now_i - changed_q;
    deb_d      = accept ? sense_i : deb_q;
    changed_d  = accept ? now_i : changed_q;
    hold_age   = accept ? '0 : held_ms;
  end

  // Event classification for this poll.
  always_comb begin
    res_o.changed = accept;
    res_o.ev      = EV_NONE;
    if (accept && !sense_i) begin
      if (held_ms < {{(TICK_W-CFG_W){1'b0}}, cfg_i.short_limit_ms}) begin
        res_o.ev = EV_SHORT;
      end else if (held_ms < {{(TICK_W-CFG_W){1'b0}}, cfg_i.long_limit_ms}) begin
        res_o.ev = EV_LONG;
      end
    end
    if (deb_d && (hold_age >= {{(TICK_W-CFG_W){1'b0}}, cfg_i.long_limit_ms})) begin
      res_o.ev = EV_HOLDING;
    end
  end

  // State update once per poll.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      deb_q      <= 1'b0;
      stable_q   <= '0;
      changed_q  <= '0;
    end else if (step_i) begin
      last_raw_q <= last_raw_d;
      deb_q      <= deb_d;
      stable_q   <= stable_d;
      changed_q  <= changed_d;
    end
  end

  assign pressed_o = deb_q;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the button debounce press classifier
// Polls with chosen ticks and pin levels go in through the input channel and
// a behavioral copy of the debouncer works out the report of every poll. A
// checker compares each result transaction, field by field, with the oldest
// pending report. Directed polls cover the special timing cases first, then
// random phases with fresh limits run press, hold and release sequences with
// bounce on them. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import bdpc_pkg::*;

  localparam int unsigned BUTTONS         = 3;
  localparam int unsigned LATENCY         = 2;
  localparam int unsigned STALL_LIMIT     = 3000;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned POLLS_PER_PHASE = 55;

  // Index beyond the last register; the block ignores writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  // Report of one poll as seen on the result channel.
  typedef struct packed {
    logic [BUTTONS-1:0]   pressed_mask;
    logic [2*BUTTONS-1:0] press_events;
    logic [TICK_W-1:0]    last_change_ms;
  } poll_report_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [TICK_W-1:0]    now_ms_i       = '0;
  logic [BUTTONS-1:0]   raw_levels_i   = '1;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [BUTTONS-1:0]   pressed_mask_o;
  logic [2*BUTTONS-1:0] press_events_o;
  logic [TICK_W-1:0]    last_change_ms_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [CFG_W-1:0]     cfg_data_i     = '0;

  // Shadow copy of the limits and of the per-button debounce state.
  logic [CFG_W-1:0]  cfg_debounce    = DEBOUNCE_RST;
  logic [CFG_W-1:0]  cfg_short_limit = SHORT_LIMIT_RST;
  logic [CFG_W-1:0]  cfg_long_limit  = LONG_LIMIT_RST;
  logic              sense_seen   [BUTTONS];
  logic              held_state   [BUTTONS];
  logic [TICK_W-1:0] level_since  [BUTTONS];
  logic [TICK_W-1:0] toggle_tick  [BUTTONS];
  logic [TICK_W-1:0] latest_toggle_tick = '0;

  poll_report_t pending_reports[$];
  int unsigned  fail_count  = 0;
  int unsigned  burst_left  = 0;
  bit           sender_gaps = 1'b1;

  button_debounce_press_classifier #(
    .NUM_BUTTONS(BUTTONS)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .now_ms_i        (now_ms_i),
    .raw_levels_i    (raw_levels_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pressed_mask_o  (pressed_mask_o),
    .press_events_o  (press_events_o),
    .last_change_ms_o(last_change_ms_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Debounce every button for one poll and classify any release or hold.
  function automatic poll_report_t classify_poll(input logic [TICK_W-1:0] tick,
                                                 input logic [BUTTONS-1:0] raw);
    poll_report_t      rep;
    logic              sense;
    logic [TICK_W-1:0] span;
    logic [TICK_W-1:0] press_start;
    press_ev_e         ev;
    rep = '0;
    for (int b = 0; b < BUTTONS; b++) begin
      sense = ~raw[b];
      ev    = EV_NONE;
      if (sense != sense_seen[b]) begin
        level_since[b] = tick;
      end
      sense_seen[b] = sense;
      span = tick - level_since[b];
      if (sense != held_state[b] && span >= {16'd0, cfg_debounce}) begin
        press_start        = toggle_tick[b];
        held_state[b]      = sense;
        toggle_tick[b]     = tick;
        latest_toggle_tick = tick;
        if (!sense) begin
          span = tick - press_start;
          if (span < {16'd0, cfg_short_limit}) begin
            ev = EV_SHORT;
          end else if (span < {16'd0, cfg_long_limit}) begin
            ev = EV_LONG;
          end
        end
      end
      // A button held at or past the long limit reports holding on every poll.
      span = tick - toggle_tick[b];
      if (held_state[b] && span >= {16'd0, cfg_long_limit}) begin
        ev = EV_HOLDING;
      end
      rep.pressed_mask[b]        = held_state[b];
      rep.press_events[2*b +: 2] = ev;
    end
    rep.last_change_ms = latest_toggle_tick;
    return rep;
  endfunction

  // Send one poll in bursts, with random gaps when sender_gaps is set; the caller is at a falling edge.
  task automatic send_poll(input logic [TICK_W-1:0] tick, input logic [BUTTONS-1:0] raw);
    if (burst_left == 0) begin
      if (sender_gaps) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i   = 1'b1;
    now_ms_i     = tick;
    raw_levels_i = raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_reports.push_back(classify_poll(tick, raw));
    @(negedge clk_i);
  endtask

  // Write one register; valid stays high across a run of writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data,
                           input bit last);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_DEBOUNCE:    cfg_debounce    = data;
      CFG_SHORT_LIMIT: cfg_short_limit = data;
      CFG_LONG_LIMIT:  cfg_long_limit  = data;
      default: ;
    endcase
    @(negedge clk_i);
    if (last) begin
      cfg_valid_i = 1'b0;
    end
  endtask

  // Stop sending, let every pending report come out, then idle.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  // Default limits: short presses on buttons 1 and 2 released together, then a long press on button 0.
  task automatic test_short_and_long_press();
    send_poll(32'd0, 3'b111);
    send_poll(32'd10, 3'b000);
    send_poll(32'd60, 3'b000);
    send_poll(32'd300, 3'b110);
    send_poll(32'd350, 3'b110);
    send_poll(32'd1500, 3'b111);
    send_poll(32'd1550, 3'b111);
  endtask

  // Holding at exactly the long limit, then a release too late to classify.
  task automatic test_hold_and_late_release();
    send_poll(32'd1600, 3'b101);
    send_poll(32'd1650, 3'b101);
    send_poll(32'd3650, 3'b101);
    send_poll(32'd3700, 3'b111);
    send_poll(32'd3750, 3'b111);
  endtask

  // Zero debounce takes a level at once; zero long limit holds on the press.
  task automatic test_zero_limits();
    wait_drained();
    write_reg(CFG_DEBOUNCE, 16'd0, 1'b0);
    write_reg(CFG_SHORT_LIMIT, 16'd0, 1'b0);
    write_reg(CFG_LONG_LIMIT, 16'd0, 1'b1);
    send_poll(32'd4000, 3'b011);
    send_poll(32'd4001, 3'b111);
    wait_drained();
    write_reg(CFG_SHORT_LIMIT, 16'hFFFF, 1'b0);
    write_reg(CFG_LONG_LIMIT, 16'hFFFF, 1'b1);
    send_poll(32'd4002, 3'b110);
    send_poll(32'd4003, 3'b111);
  endtask

  // A press across the tick wrap, then a release with time going backward.
  task automatic test_tick_wrap_and_backward();
    wait_drained();
    write_reg(CFG_DEBOUNCE, 16'd20, 1'b0);
    write_reg(CFG_SHORT_LIMIT, 16'd100, 1'b0);
    write_reg(CFG_LONG_LIMIT, 16'd200, 1'b1);
    send_poll(32'hFFFF_FFF0, 3'b110);
    send_poll(32'h0000_0004, 3'b110);
    send_poll(32'h0000_0010, 3'b111);
    send_poll(32'h0000_0000, 3'b111);
  endtask

  // Largest debounce, all-ones limits, and writes to the unused index.
  task automatic test_max_debounce_and_spare_index();
    wait_drained();
    write_reg(CFG_DEBOUNCE, 16'hFFFF, 1'b0);
    write_reg(CFG_IDX_SPARE, 16'hFFFF, 1'b0);
    write_reg(CFG_IDX_SPARE, 16'h0000, 1'b0);
    write_reg(CFG_SHORT_LIMIT, 16'hFFFF, 1'b0);
    write_reg(CFG_LONG_LIMIT, 16'hFFFF, 1'b1);
    send_poll(32'd100, 3'b110);
    send_poll(32'd65634, 3'b110);
    send_poll(32'd65635, 3'b110);
    send_poll(32'd200000, 3'b111);
    send_poll(32'd265535, 3'b111);
  endtask

  // Mostly small limits, now and then zero or the largest value.
  function automatic logic [CFG_W-1:0] pick_limit(input int unsigned typical_max);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      return '0;
    end else if (roll < 15) begin
      return '1;
    end
    return CFG_W'($urandom_range(1, typical_max));
  endfunction

  // Random phases: each picks limits, then runs bouncy press sequences.
  task automatic test_random_polls();
    logic [TICK_W-1:0]  tick;
    logic [BUTTONS-1:0] intent;
    logic [BUTTONS-1:0] bounce;
    int unsigned        step;
    int unsigned        roll;
    intent = '0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      sender_gaps = (phase % 4) != 3;
      write_reg(CFG_DEBOUNCE, pick_limit(30), 1'b0);
      write_reg(CFG_SHORT_LIMIT, pick_limit(300), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_LONG_LIMIT, pick_limit(600), 1'b0);
        write_reg(CFG_IDX_SPARE, CFG_W'($urandom()), 1'b1);
      end else begin
        write_reg(CFG_LONG_LIMIT, pick_limit(600), 1'b1);
      end
      if ($urandom_range(0, 3) == 0) begin
        tick = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      end else begin
        tick = $urandom();
      end
      for (int n = 0; n < POLLS_PER_PHASE; n++) begin
        // Mostly steps around the debounce time, some up to a quarter of the long limit, a few backward or random.
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          step = $urandom_range(0, 2 * cfg_debounce + 10);
        end else if (roll < 95) begin
          step = $urandom_range(0, cfg_long_limit / 4 + 20);
        end else if (roll < 98) begin
          step = 32'd0 - $urandom_range(1, 100);
        end else begin
          step = $urandom();
        end
        tick = tick + step;
        // Intended presses change now and then; bounce flips single polls.
        bounce = '0;
        for (int b = 0; b < BUTTONS; b++) begin
          if ($urandom_range(0, 99) < 15) begin
            intent[b] = ~intent[b];
          end
          if ($urandom_range(0, 99) < 8) begin
            bounce[b] = 1'b1;
          end
        end
        send_poll(tick, ~intent ^ bounce);
      end
    end
    sender_gaps = 1'b1;
  endtask

  // Receiver: ready pattern changes between always, random and sparse.
  initial begin : result_sink
    int unsigned mode;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk_i);
        case (mode)
          0:       out_ready_i = 1'b1;
          1:       out_ready_i = 1'($urandom_range(0, 1));
          default: out_ready_i = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest pending report.
  always @(posedge clk_i) begin
    poll_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with no poll pending");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (pressed_mask_o !== want.pressed_mask) begin
          $error("pressed_mask: expected %0h, actual %0h", want.pressed_mask,
                 pressed_mask_o);
          fail_count++;
        end
        if (press_events_o !== want.press_events) begin
          $error("press_events: expected %0h, actual %0h", want.press_events,
                 press_events_o);
          fail_count++;
        end
        if (last_change_ms_o !== want.last_change_ms) begin
          $error("last_change_ms: expected %0h, actual %0h", want.last_change_ms,
                 last_change_ms_o);
          fail_count++;
        end
      end
    end
  end

  // Stop the run when no channel has moved a transaction for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main_sequence
    for (int b = 0; b < BUTTONS; b++) begin
      sense_seen[b]  = 1'b0;
      held_state[b]  = 1'b0;
      level_since[b] = '0;
      toggle_tick[b] = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_short_and_long_press();
    test_hold_and_late_release();
    test_zero_limits();
    test_tick_wrap_and_backward();
    test_max_debounce_and_spare_index();
    test_random_polls();

    wait_drained();
    if (pending_reports.size() != 0) begin
      $error("%0d poll reports never arrived", pending_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
